[sv/msd_pkg.sv]
// Shared constants of the mean and standard deviation block.
package msd_pkg;
    localparam int SampleW = 24;
    localparam int StdW    = 23;
    localparam int CountW  = 8;
    localparam int DiffW   = SampleW + 1;
    localparam int SquareW = 2 * DiffW;
    localparam int VarW    = 2 * SampleW;
    localparam int RootW   = SampleW;
    localparam int SqRemW  = RootW + 3;
endpackage

[sv/msd_queue.sv]
// Two-entry job queue between the sample front end and the arithmetic back end.
module msd_queue #(
    parameter int W = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] dout
);
    logic [W-1:0] data_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign valid = (fill_reg != 2'd0);
    assign dout  = data_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push && !full) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && valid) begin
                rptr_reg <= ~rptr_reg;
            end
            fill_reg <= fill_reg + 2'(push && !full) - 2'(pop && valid);
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            data_reg[wptr_reg] <= din;
        end
    end
endmodule

[sv/msd_front.sv]
// Front end: accepts sample beats, writes the store and keeps the running sum and count.
module msd_front #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [msd_pkg::SampleW-1:0]   sample,
    input  logic                          last,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [msd_pkg::SampleW+2*$clog2(MAX_SAMPLES+1):0] q_data,
    output logic                          wr_en,
    output logic [$clog2(MAX_SAMPLES)-1:0] wr_addr,
    output logic [msd_pkg::SampleW-1:0]   wr_data,
    input  logic                          store_free
);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int SUM_W = msd_pkg::SampleW + CW;

    logic [CW-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    ovf_reg, ovf_next;
    logic                    hold_reg;
    logic                    take, room;

    assign s_ready = !hold_reg && !q_full;
    assign take    = s_valid && s_ready;
    assign room    = (count_reg < CW'(MAX_SAMPLES));

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        if (room) begin
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + SUM_W'($signed(sample));
        end else begin
            ovf_next = 1'b1;
        end
    end

    assign wr_en   = take && room;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = sample;
    assign q_push  = take && last;
    assign q_data  = {ovf_next, count_next, sum_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            hold_reg  <= 1'b0;
        end else begin
            if (take) begin
                if (last) begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    hold_reg  <= 1'b1;
                end else begin
                    count_reg <= count_next;
                    sum_reg   <= sum_next;
                    ovf_reg   <= ovf_next;
                end
            end else if (store_free) begin
                hold_reg <= 1'b0;
            end
        end
    end
endmodule

[sv/msd_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the mean and the variance.
module msd_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);
    localparam int KW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [KW-1:0]    k_reg;
    logic             busy_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, q_reg[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign busy    = busy_reg;
    assign quo     = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            k_reg    <= KW'(NUM_W);
        end else if (busy_reg) begin
            k_reg <= k_reg - KW'(1);
            if (k_reg == KW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so its top bit drops away.
            rem_reg <= fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], fits};
        end
    end
endmodule

[sv/msd_back.sv]
// Back end: sample store, mean, squared-deviation pass, variance and square root.
module msd_back #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_SAMPLES)-1:0] wr_addr,
    input  logic [msd_pkg::SampleW-1:0]   wr_data,
    input  logic                          q_valid,
    input  logic [msd_pkg::SampleW+2*$clog2(MAX_SAMPLES+1):0] q_data,
    output logic                          q_pop,
    output logic                          store_free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [msd_pkg::SampleW-1:0]   mean,
    output logic [msd_pkg::StdW-1:0]      std_dev,
    output logic [msd_pkg::CountW-1:0]    sample_count,
    output logic                          status
);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int SUM_W = msd_pkg::SampleW + CW;
    localparam int SQ_W  = msd_pkg::SquareW + CW;
    localparam int RW    = msd_pkg::RootW;
    localparam int SRW   = msd_pkg::SqRemW;
    localparam int SKW   = $clog2(RW + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MEAN = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_VAR  = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [msd_pkg::SampleW-1:0] mem [MAX_SAMPLES];
    logic [msd_pkg::SampleW-1:0] rdata_reg;

    logic [2:0]                    state_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [CW-1:0]                 cnt_reg, idx_reg;
    logic                          ovf_reg, neg_reg;
    logic [msd_pkg::SampleW-1:0]   mean_reg;
    logic [2:0]                    pipe_reg;
    logic [msd_pkg::DiffW-1:0]     dabs_reg;
    logic [msd_pkg::SquareW-1:0]   sq_reg;
    logic [SQ_W-1:0]               acc_reg;
    logic [msd_pkg::VarW-1:0]      var_reg;
    logic [SRW-1:0]                srem_reg;
    logic [RW-1:0]                 root_reg;
    logic [SKW-1:0]                sk_reg;

    logic                          div_start, div_busy;
    logic [SQ_W-1:0]               div_num, div_quo;
    logic [CW-1:0]                 div_den;
    logic [SUM_W-1:0]              sum_mag;
    logic [msd_pkg::SampleW-1:0]   q_mean;
    logic signed [msd_pkg::DiffW-1:0] diff;
    logic [SRW-1:0]                srem_sh, strial;

    logic                          out_valid_reg;
    logic [msd_pkg::SampleW-1:0]   out_mean_reg;
    logic [msd_pkg::StdW-1:0]      out_std_reg;
    logic [msd_pkg::CountW-1:0]    out_cnt_reg;
    logic                          out_ovf_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[idx_reg[AW-1:0]];
    end

    msd_div #(.NUM_W(SQ_W), .DEN_W(CW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo)
    );

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign q_mean  = div_quo[msd_pkg::SampleW-1:0];
    assign diff    = $signed({rdata_reg[msd_pkg::SampleW-1], rdata_reg})
                   - $signed({mean_reg[msd_pkg::SampleW-1], mean_reg});
    assign srem_sh = {srem_reg[SRW-3:0], var_reg[msd_pkg::VarW-1:msd_pkg::VarW-2]};
    assign strial  = {1'b0, root_reg, 2'b01};
    assign store_free = (state_reg == ST_SCAN) && (idx_reg == cnt_reg) && (pipe_reg == 3'd0);

    always_comb begin
        div_start = 1'b0;
        div_num   = SQ_W'(sum_mag);
        div_den   = cnt_reg;
        if ((state_reg == ST_IDLE) && q_valid) begin
            // The count is still on its way into cnt_reg, so take it from the job.
            div_start = 1'b1;
            div_num   = SQ_W'(q_data[SUM_W-1:0] ^ {SUM_W{q_data[SUM_W-1]}})
                      + SQ_W'(q_data[SUM_W-1]);
            div_den   = q_data[SUM_W+CW-1:SUM_W];
        end else if (store_free) begin
            div_start = 1'b1;
            div_num   = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pipe_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    if (!div_busy) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    pipe_reg <= {pipe_reg[1:0], idx_reg != cnt_reg};
                    if (store_free) begin
                        state_reg <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    if (!div_busy) begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sk_reg == SKW'(1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                sum_reg <= q_data[SUM_W-1:0];
                cnt_reg <= q_data[SUM_W+CW-1:SUM_W];
                ovf_reg <= q_data[SUM_W+CW];
                neg_reg <= q_data[SUM_W-1];
            end
            ST_MEAN: begin
                // Truncation toward zero: divide the magnitude and restore the sign.
                mean_reg <= neg_reg ? -q_mean : q_mean;
                idx_reg  <= '0;
                acc_reg  <= '0;
            end
            ST_SCAN: begin
                if (idx_reg != cnt_reg) begin
                    idx_reg <= idx_reg + CW'(1);
                end
                dabs_reg <= diff[msd_pkg::DiffW-1] ? msd_pkg::DiffW'(-diff)
                                                   : msd_pkg::DiffW'(diff);
                sq_reg   <= dabs_reg * dabs_reg;
                if (pipe_reg[2]) begin
                    acc_reg <= acc_reg + SQ_W'(sq_reg);
                end
            end
            ST_VAR: begin
                var_reg  <= div_quo[msd_pkg::VarW-1:0];
                srem_reg <= '0;
                root_reg <= '0;
                sk_reg   <= SKW'(RW);
            end
            ST_ROOT: begin
                var_reg <= {var_reg[msd_pkg::VarW-3:0], 2'b00};
                sk_reg  <= sk_reg - SKW'(1);
                if (srem_sh >= strial) begin
                    srem_reg <= srem_sh - strial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    srem_reg <= srem_sh;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_mean_reg <= mean_reg;
                    out_std_reg  <= root_reg[msd_pkg::StdW-1:0];
                    out_cnt_reg  <= msd_pkg::CountW'(cnt_reg);
                    out_ovf_reg  <= ovf_reg;
                end
            end
            default: begin
                idx_reg <= '0;
            end
        endcase
    end

    assign m_valid      = out_valid_reg;
    assign mean         = out_mean_reg;
    assign std_dev      = out_std_reg;
    assign sample_count = out_cnt_reg;
    assign status       = out_ovf_reg;
endmodule

[sv/mean_and_standard_deviation.sv]
// Top level: one sample per beat, one result beat per set closed by tlast.
// Samples are accepted one per cycle while the job queue has room; the beat after a
// tlast beat waits until the back end has read the store.
// After tlast the result passes through the serial divider for the mean, the store scan,
// the divider again for the variance and the 24-step square root.
// aresetn, synchronous and active low, empties the queue and clears the front end's sum and count.
module mean_and_standard_deviation #(
    parameter int MAX_SAMPLES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // sample[23:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // mean[23:0], std_dev[46:24], sample_count[54:47], zero
    output logic        m_tuser   // status
);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int QW = msd_pkg::SampleW + 2 * CW + 1;

    logic          q_full, q_push, q_pop, q_valid, wr_en, store_free;
    logic [QW-1:0] q_in, q_out;
    logic [AW-1:0] wr_addr;
    logic [23:0]   wr_data, mean;
    logic [22:0]   std_dev;
    logic [7:0]    sample_count;

    msd_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_tvalid), .s_ready(s_tready),
        .sample(s_tdata), .last(s_tlast), .q_full(q_full), .q_push(q_push),
        .q_data(q_in), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .store_free(store_free)
    );

    msd_queue #(.W(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .din(q_in), .full(q_full),
        .pop(q_pop), .valid(q_valid), .dout(q_out)
    );

    msd_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
        .store_free(store_free), .m_valid(m_tvalid), .m_ready(m_tready),
        .mean(mean), .std_dev(std_dev), .sample_count(sample_count), .status(m_tuser)
    );

    assign m_tdata = {1'b0, sample_count, std_dev, mean};
endmodule
